// ----- design/minv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_pkg
// Shared widths, step-unit modes and control types for the modular inverse.
// ----------------------------------------------------------------------------
package minv_pkg;

    localparam int FIELD_W       = 31;
    localparam int WIDTH_DEFAULT = 32;

    typedef enum logic {
        MODE_EUCLID,
        MODE_FIX
    } step_mode_t;

    typedef struct packed {
        logic u_zero;
        logic v_one;
        logic fix_done;
    } step_flags_t;

endpackage

// ----- design/minv_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_req_if
// Request channel: value and modulus beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface minv_req_if;
    import minv_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);

endinterface

// ----- design/minv_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_rsp_if
// Response channel: inverse and status beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface minv_rsp_if;
    import minv_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] inverse;
    logic               status;

    modport source (output valid, output inverse, output status, input ready);
    modport sink   (input valid, input inverse, input status, output ready);

endinterface

// ----- design/minv_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_step
// Shared step unit: one binary extended-Euclid move, or one final
// correction of the coefficient into the range of the modulus.
// ----------------------------------------------------------------------------
module minv_step #(
    parameter int DW = 32,
    parameter int CW = DW + 3
) (
    input  minv_pkg::step_mode_t   mode,
    input  logic [DW-1:0]          x,
    input  logic [DW-1:0]          y,
    input  logic [DW-1:0]          u,
    input  logic [DW-1:0]          v,
    input  logic signed [CW-1:0]   a,
    input  logic signed [CW-1:0]   b,
    input  logic signed [CW-1:0]   c,
    input  logic signed [CW-1:0]   d,
    output logic [DW-1:0]          u_next,
    output logic [DW-1:0]          v_next,
    output logic signed [CW-1:0]   a_next,
    output logic signed [CW-1:0]   b_next,
    output logic signed [CW-1:0]   c_next,
    output logic signed [CW-1:0]   d_next,
    output minv_pkg::step_flags_t  flags
);
    import minv_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] p_sel;
    logic signed [CW-1:0] q_sel;
    logic signed [CW-1:0] p_half;
    logic signed [CW-1:0] q_half;

    assign xs = signed'({{(CW-DW){1'b0}}, x});
    assign ys = signed'({{(CW-DW){1'b0}}, y});

    assign flags.u_zero   = (u == '0);
    assign flags.v_one    = (v == DW'(1));
    assign flags.fix_done = !c[CW-1] && (c < ys);

    // halve the coefficient pair that belongs to the even operand
    always_comb
    begin
        p_sel = (!u[0]) ? a : c;
        q_sel = (!u[0]) ? b : d;
        if (p_sel[0] || q_sel[0])
        begin
            p_half = (p_sel + ys) >>> 1;
            q_half = (q_sel - xs) >>> 1;
        end
        else
        begin
            p_half = p_sel >>> 1;
            q_half = q_sel >>> 1;
        end
    end

    always_comb
    begin
        u_next = u;
        v_next = v;
        a_next = a;
        b_next = b;
        c_next = c;
        d_next = d;
        unique case (mode)
            MODE_EUCLID:
            begin
                priority if (!u[0])
                begin
                    u_next = u >> 1;
                    a_next = p_half;
                    b_next = q_half;
                end
                else if (!v[0])
                begin
                    v_next = v >> 1;
                    c_next = p_half;
                    d_next = q_half;
                end
                else if (u >= v)
                begin
                    u_next = u - v;
                    a_next = a - c;
                    b_next = b - d;
                end
                else
                begin
                    v_next = v - u;
                    c_next = c - a;
                    d_next = d - b;
                end
            end
            MODE_FIX:
            begin
                priority if (c[CW-1])
                begin
                    c_next = c + ys;
                end
                else if (c >= ys)
                begin
                    c_next = c - ys;
                end
                else
                begin
                    c_next = c;
                end
            end
            default:
            begin
                u_next = u;
            end
        endcase
    end

endmodule

// ----- design/modular_inverse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse
// Modular inverse by binary extended Euclid on a single shared step unit.
// A zero value, a modulus below two or two even operands go from the request
// beat to ST_DONE; else ST_RUN takes step moves, then ST_FIX takes range
// corrections when an inverse exists, and ST_DONE loads the response.
// Throughput: one item at a time, next beat once the result is loaded.
// Reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module modular_inverse #(
    parameter int WIDTH = minv_pkg::WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    minv_req_if.sink          req,
    minv_rsp_if.source        rsp
);
    import minv_pkg::*;

    localparam int DW = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;
    localparam int CW = DW + 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic                 rsp_valid_reg;
    logic                 err_reg;

    logic [DW-1:0]        x_reg;
    logic [DW-1:0]        y_reg;
    logic [DW-1:0]        u_reg;
    logic [DW-1:0]        v_reg;
    logic signed [CW-1:0] a_reg;
    logic signed [CW-1:0] b_reg;
    logic signed [CW-1:0] c_reg;
    logic signed [CW-1:0] d_reg;
    logic [FIELD_W-1:0]   inverse_reg;
    logic                 status_reg;

    logic [DW-1:0]        u_next;
    logic [DW-1:0]        v_next;
    logic signed [CW-1:0] a_next;
    logic signed [CW-1:0] b_next;
    logic signed [CW-1:0] c_next;
    logic signed [CW-1:0] d_next;
    step_flags_t          flags;
    step_mode_t           mode;

    logic                 req_beat;
    logic                 rsp_free;
    logic                 load_rsp;
    logic [DW-1:0]        in_x;
    logic [DW-1:0]        in_y;
    logic                 in_bad;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_beat  = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign load_rsp  = (state_reg == ST_DONE) && rsp_free;

    assign in_x   = DW'(req.value);
    assign in_y   = DW'(req.modulus);
    assign in_bad = (in_y < DW'(2)) || (in_x == '0) || (!in_x[0] && !in_y[0]);

    assign mode = (state_reg == ST_FIX) ? MODE_FIX : MODE_EUCLID;

    minv_step #(
        .DW (DW),
        .CW (CW)
    ) u_step (
        .mode   (mode),
        .x      (x_reg),
        .y      (y_reg),
        .u      (u_reg),
        .v      (v_reg),
        .a      (a_reg),
        .b      (b_reg),
        .c      (c_reg),
        .d      (d_reg),
        .u_next (u_next),
        .v_next (v_next),
        .a_next (a_next),
        .b_next (b_next),
        .c_next (c_next),
        .d_next (d_next),
        .flags  (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && !load_rsp)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_beat)
                    begin
                        err_reg   <= in_bad;
                        state_reg <= in_bad ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (flags.u_zero)
                    begin
                        err_reg   <= !flags.v_one;
                        state_reg <= flags.v_one ? ST_FIX : ST_DONE;
                    end
                end
                ST_FIX:
                begin
                    if (flags.fix_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            x_reg <= in_x;
            y_reg <= in_y;
            u_reg <= in_x;
            v_reg <= in_y;
            a_reg <= CW'(1);
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= CW'(1);
        end
        else if ((state_reg == ST_RUN && !flags.u_zero) ||
                 (state_reg == ST_FIX && !flags.fix_done))
        begin
            u_reg <= u_next;
            v_reg <= v_next;
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
        if (load_rsp)
        begin
            inverse_reg <= err_reg ? '0 : c_reg[FIELD_W-1:0];
            status_reg  <= err_reg;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.inverse = inverse_reg;
    assign rsp.status  = status_reg;

endmodule

// ----- design/minv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_checker
// Port-level checks for the modular inverse, bound to the top level.
// ----------------------------------------------------------------------------
module minv_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [minv_pkg::FIELD_W-1:0] out_inverse,
    input logic                         out_status
);
    import minv_pkg::*;

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while an item is in flight");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status |-> out_inverse == '0)
        else $error("error beat carries a nonzero inverse");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_status |-> out_inverse != '0)
        else $error("good beat carries a zero inverse");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_inverse) && $stable(out_status))
        else $error("response payload changed while stalled");

endmodule

bind modular_inverse minv_checker u_minv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_inverse (rsp.inverse),
    .out_status  (rsp.status)
);
